// ----- design/sct_pkg.sv -----
// Shared types, token codes and byte constants for the shell command tokenizer.
// Used by sct_lexer, sct_result_fifo and shell_command_tokenizer_core.
package sct_pkg;

  localparam int unsigned LINE_MAX   = 1024;
  localparam int unsigned FIFO_DEPTH = 4;

  localparam int unsigned KIND_W   = 4;
  localparam int unsigned START_W  = 10;
  localparam int unsigned LENGTH_W = 11;
  localparam int unsigned CAUSE_W  = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_WORD   = 4'd0,
    KIND_AND    = 4'd1,
    KIND_OR     = 4'd2,
    KIND_PIPE   = 4'd3,
    KIND_LT     = 4'd4,
    KIND_GT     = 4'd5,
    KIND_SEMI   = 4'd6,
    KIND_LPAREN = 4'd7,
    KIND_RPAREN = 4'd8,
    KIND_EOF    = 4'd9,
    KIND_ERROR  = 4'd10
  } kind_e;

  typedef enum logic [CAUSE_W-1:0] {
    CAUSE_NONE     = 2'd0,
    CAUSE_LONE_AMP = 2'd1,
    CAUSE_TOO_LONG = 2'd2
  } cause_e;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_AMP  = 2'd1,
    PEND_PIPE = 2'd2
  } pend_e;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  typedef struct packed {
    kind_e                kind;
    logic [START_W-1:0]   start_res;
    logic [LENGTH_W-1:0]  length;
    cause_e               error_cause;
    logic                 last;
  } token_t;

  typedef struct packed {
    logic [1:0]       num;
    token_t [1:0]     tok;
  } push_t;

  function automatic token_t mk_token(kind_e kind, logic [START_W-1:0] start_res,
                                      logic [LENGTH_W-1:0] length, cause_e cause);
    token_t t;
    t.kind        = kind;
    t.start_res   = start_res;
    t.length      = length;
    t.error_cause = cause;
    t.last        = 1'b0;
    return t;
  endfunction

endpackage

// ----- design/sct_lexer.sv -----
// Line state and per-byte token logic of the shell command tokenizer.
// Produces up to two tokens per accepted byte; depends on sct_pkg.
module sct_lexer #(
  parameter int unsigned LineMax = sct_pkg::LINE_MAX
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    ch_i,
  output sct_pkg::push_t push_o
);

  localparam int unsigned PosW = $clog2(LineMax + 1);

  logic [PosW-1:0]  pos_q, pos_d;
  logic [PosW-1:0]  wstart_q, wstart_d;
  logic             in_word_q, in_word_d;
  sct_pkg::pend_e   pend_q, pend_d;
  logic             disc_q, disc_d;

  logic [PosW-1:0]  pos_m1;
  logic [PosW-1:0]  word_len;
  logic             is_blank;
  logic             is_meta;
  logic             is_nul;
  logic [1:0]       cnt;
  sct_pkg::token_t [1:0] tok;

  assign pos_m1   = pos_q - PosW'(1);
  assign word_len = pos_q - wstart_q;
  assign is_nul   = (ch_i == sct_pkg::CH_NUL);
  assign is_blank = ch_i inside {sct_pkg::CH_SPACE, sct_pkg::CH_TAB, sct_pkg::CH_LF,
                                 sct_pkg::CH_VT, sct_pkg::CH_FF, sct_pkg::CH_CR};
  assign is_meta  = ch_i inside {sct_pkg::CH_LT, sct_pkg::CH_GT, sct_pkg::CH_PIPE,
                                 sct_pkg::CH_AMP, sct_pkg::CH_SEMI, sct_pkg::CH_LPAREN,
                                 sct_pkg::CH_RPAREN};

  always_comb begin
    pos_d     = pos_q;
    wstart_d  = wstart_q;
    in_word_d = in_word_q;
    pend_d    = pend_q;
    disc_d    = disc_q;
    cnt       = 2'd0;
    tok       = '0;

    if (disc_q) begin
      if (is_nul) begin
        tok[0]    = sct_pkg::mk_token(sct_pkg::KIND_EOF, '0, '0, sct_pkg::CAUSE_NONE);
        cnt       = 2'd1;
        pos_d     = '0;
        wstart_d  = '0;
        in_word_d = 1'b0;
        pend_d    = sct_pkg::PEND_NONE;
        disc_d    = 1'b0;
      end
    end else if (!is_nul && (pos_q >= PosW'(LineMax))) begin
      tok[0]    = sct_pkg::mk_token(sct_pkg::KIND_ERROR, '0, '0, sct_pkg::CAUSE_TOO_LONG);
      cnt       = 2'd1;
      in_word_d = 1'b0;
      pend_d    = sct_pkg::PEND_NONE;
      disc_d    = 1'b1;
    end else if (pend_q == sct_pkg::PEND_AMP) begin
      pend_d = sct_pkg::PEND_NONE;
      if (ch_i == sct_pkg::CH_AMP) begin
        tok[0] = sct_pkg::mk_token(sct_pkg::KIND_AND, sct_pkg::START_W'(pos_m1), '0,
                                   sct_pkg::CAUSE_NONE);
        cnt    = 2'd1;
        pos_d  = pos_q + PosW'(1);
      end else begin
        tok[0] = sct_pkg::mk_token(sct_pkg::KIND_ERROR, sct_pkg::START_W'(pos_m1), '0,
                                   sct_pkg::CAUSE_LONE_AMP);
        cnt    = 2'd1;
        if (is_nul) begin
          tok[1]    = sct_pkg::mk_token(sct_pkg::KIND_EOF, '0, '0, sct_pkg::CAUSE_NONE);
          cnt       = 2'd2;
          pos_d     = '0;
          wstart_d  = '0;
          in_word_d = 1'b0;
        end else begin
          disc_d = 1'b1;
        end
      end
    end else if ((pend_q == sct_pkg::PEND_PIPE) && (ch_i == sct_pkg::CH_PIPE)) begin
      pend_d = sct_pkg::PEND_NONE;
      tok[0] = sct_pkg::mk_token(sct_pkg::KIND_OR, sct_pkg::START_W'(pos_m1), '0,
                                 sct_pkg::CAUSE_NONE);
      cnt    = 2'd1;
      pos_d  = pos_q + PosW'(1);
    end else begin
      if (pend_q == sct_pkg::PEND_PIPE) begin
        pend_d = sct_pkg::PEND_NONE;
        tok[0] = sct_pkg::mk_token(sct_pkg::KIND_PIPE, sct_pkg::START_W'(pos_m1), '0,
                                   sct_pkg::CAUSE_NONE);
        cnt    = 2'd1;
      end
      if (in_word_q && (is_nul || is_blank || is_meta)) begin
        tok[cnt[0]] = sct_pkg::mk_token(sct_pkg::KIND_WORD, sct_pkg::START_W'(wstart_q),
                                        sct_pkg::LENGTH_W'(word_len), sct_pkg::CAUSE_NONE);
        cnt       = cnt + 2'd1;
        in_word_d = 1'b0;
      end
      if (is_nul) begin
        tok[cnt[0]] = sct_pkg::mk_token(sct_pkg::KIND_EOF, '0, '0, sct_pkg::CAUSE_NONE);
        cnt       = cnt + 2'd1;
        pos_d     = '0;
        wstart_d  = '0;
        in_word_d = 1'b0;
        pend_d    = sct_pkg::PEND_NONE;
      end else begin
        pos_d = pos_q + PosW'(1);
        if (is_blank) begin
          pend_d = sct_pkg::PEND_NONE;
        end else if (ch_i == sct_pkg::CH_AMP) begin
          pend_d = sct_pkg::PEND_AMP;
        end else if (ch_i == sct_pkg::CH_PIPE) begin
          pend_d = sct_pkg::PEND_PIPE;
        end else if (is_meta) begin
          tok[cnt[0]] = sct_pkg::mk_token(sct_pkg::KIND_LT, sct_pkg::START_W'(pos_q), '0,
                                          sct_pkg::CAUSE_NONE);
          case (ch_i)
            sct_pkg::CH_LT:     tok[cnt[0]].kind = sct_pkg::KIND_LT;
            sct_pkg::CH_GT:     tok[cnt[0]].kind = sct_pkg::KIND_GT;
            sct_pkg::CH_SEMI:   tok[cnt[0]].kind = sct_pkg::KIND_SEMI;
            sct_pkg::CH_LPAREN: tok[cnt[0]].kind = sct_pkg::KIND_LPAREN;
            default:            tok[cnt[0]].kind = sct_pkg::KIND_RPAREN;
          endcase
          cnt = cnt + 2'd1;
        end else if (!in_word_q) begin
          in_word_d = 1'b1;
          wstart_d  = pos_q;
        end
      end
    end

    if (cnt != 2'd0) begin
      tok[!cnt[0]].last = 1'b1;
    end
  end

  assign push_o.num = accept_i ? cnt : 2'd0;
  assign push_o.tok = tok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      wstart_q  <= '0;
      in_word_q <= 1'b0;
      pend_q    <= sct_pkg::PEND_NONE;
      disc_q    <= 1'b0;
    end else if (accept_i) begin
      pos_q     <= pos_d;
      wstart_q  <= wstart_d;
      in_word_q <= in_word_d;
      pend_q    <= pend_d;
      disc_q    <= disc_d;
    end
  end

endmodule

// ----- design/sct_result_fifo.sv -----
// Result queue of the shell command tokenizer: two writes, one read per cycle.
// Holds finished tokens until the output side takes them; depends on sct_pkg.
module sct_result_fifo #(
  parameter int unsigned Depth = sct_pkg::FIFO_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sct_pkg::push_t  push_i,
  input  logic            pop_i,
  output logic            full2_o,
  output logic            valid_o,
  output sct_pkg::token_t tok_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  sct_pkg::token_t [Depth-1:0] mem_q;
  logic [PtrW-1:0] wr_q, wr_d, wr_p1, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  function automatic logic [PtrW-1:0] inc(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign pop     = pop_i && (cnt_q != '0);
  assign wr_p1   = inc(wr_q);
  assign valid_o = (cnt_q != '0);
  assign tok_o   = mem_q[rd_q];
  assign full2_o = (cnt_q > CntW'(Depth - 2));

  always_comb begin
    wr_d = wr_q;
    case (push_i.num)
      2'd1:    wr_d = wr_p1;
      2'd2:    wr_d = inc(wr_p1);
      default: wr_d = wr_q;
    endcase
    rd_d  = pop ? inc(rd_q) : rd_q;
    cnt_d = cnt_q + CntW'(push_i.num) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.tok[0];
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_p1] <= push_i.tok[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- design/shell_command_tokenizer_core.sv -----
// Top level of the shell command tokenizer: byte lexer feeding a result queue.
// Depends on sct_pkg, sct_lexer and sct_result_fifo.
//
//   channel | direction | handshake                  | payload
//   input   | in        | in_valid_i / in_stall_o    | ch_i
//   output  | out       | out_valid_o / out_stall_i  | kind_o start_res_o length_o
//           |           |                            | error_cause_o last_o
//
// One byte is taken per cycle unless in_stall_o is high; its tokens enter the queue
// at the same edge and show on the output from the next cycle at the earliest, one
// token per cycle unless out_stall_i is high. A byte that yields two tokens puts
// both in the queue, whose depth (FIFO_DEPTH) lets input continue while they drain.
// in_stall_o rises when fewer than two queue entries are free.
// Reset clears line state and the queue; no result is pending after reset.
module shell_command_tokenizer_core #(
  parameter int unsigned LineMax   = sct_pkg::LINE_MAX,
  parameter int unsigned FifoDepth = sct_pkg::FIFO_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    ch_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sct_pkg::KIND_W-1:0]    kind_o,
  output logic [sct_pkg::START_W-1:0]   start_res_o,
  output logic [sct_pkg::LENGTH_W-1:0]  length_o,
  output logic [sct_pkg::CAUSE_W-1:0]   error_cause_o,
  output logic                          last_o
);

  sct_pkg::push_t  push;
  sct_pkg::token_t tok;
  logic            full2;
  logic            accept;

  assign in_stall_o = full2;
  assign accept     = in_valid_i && !full2;

  sct_lexer #(
    .LineMax (LineMax)
  ) u_lexer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .ch_i     (ch_i),
    .push_o   (push)
  );

  sct_result_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (!out_stall_i),
    .full2_o (full2),
    .valid_o (out_valid_o),
    .tok_o   (tok)
  );

  assign kind_o        = tok.kind;
  assign start_res_o   = tok.start_res;
  assign length_o      = tok.length;
  assign error_cause_o = tok.error_cause;
  assign last_o        = tok.last;

endmodule
